// ----- rtl/core/bbf_pkg.sv -----
// Shared types and constants of the bounded byte FIFO with end-of-input flag.
// No dependencies; every other file of the block uses this package.
package bbf_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 11;
  localparam int LEN_W  = 7;
  localparam int OP_W   = 3;
  localparam int TOT_W  = 32;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_PEEK  = 3'd2,
    OP_POP   = 3'd3,
    OP_END   = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPORT,
    ST_FETCH,
    ST_LOAD
  } seq_state_t;

endpackage

// ----- rtl/core/bbf_req_if.sv -----
// Request channel of the byte FIFO: one operation per transaction.
// Depends on bbf_pkg for the field widths.
interface bbf_req_if;

  logic                          valid;
  logic                          ready;
  logic [bbf_pkg::OP_W-1:0]      op;
  logic [bbf_pkg::BYTE_W-1:0]    data_byte;
  logic [bbf_pkg::LEN_W-1:0]     read_len;

  modport source (output valid, output op, output data_byte, output read_len,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input read_len,
                  output ready);

endinterface

// ----- rtl/core/bbf_rsp_if.sv -----
// Result channel of the byte FIFO: one delivered byte or status per transaction.
// Depends on bbf_pkg for the field widths.
interface bbf_rsp_if;

  logic                          valid;
  logic                          ready;
  logic [bbf_pkg::BYTE_W-1:0]    out_byte;
  logic                          out_valid;
  logic                          last;
  logic                          write_accepted;
  logic [bbf_pkg::CNT_W-1:0]     buffered_count;
  logic [bbf_pkg::CNT_W-1:0]     space_left;
  logic                          input_closed;
  logic                          at_eof;
  logic [bbf_pkg::TOT_W-1:0]     total_written;
  logic [bbf_pkg::TOT_W-1:0]     total_read;

  modport source (output valid, output out_byte, output out_valid, output last,
                  output write_accepted, output buffered_count, output space_left,
                  output input_closed, output at_eof, output total_written,
                  output total_read, input ready);
  modport sink   (input valid, input out_byte, input out_valid, input last,
                  input write_accepted, input buffered_count, input space_left,
                  input input_closed, input at_eof, input total_written,
                  input total_read, output ready);

endinterface

// ----- rtl/core/bounded_byte_fifo_with_eof.sv -----
// Top level of the bounded byte FIFO with end-of-input flag.
// Depends on bbf_pkg, bbf_req_if, bbf_rsp_if, bbf_store and bbf_wrap_add.
//
//   Channel   Direction  Handshake           Carries
//   req       in         valid/ready         op, data_byte, read_len
//   rsp       out        valid/ready         delivered byte and status
//   cfg       in         cfg_wr_en only      capacity (cfg_wr_data)
//
// A write, pop, end-input, unused opcode, or empty read or peek is accepted, then reported.
// A read or peek of n bytes is accepted, then runs one memory fetch and one
// output load per byte through the single registered read port.
// A stalled result holds the sequencer; req is ready only while it is idle.
// Reset is synchronous; it clears the counters and flags and restores the
// default capacity at once.
module bounded_byte_fifo_with_eof #(
  parameter int DEPTH     = bbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bbf_pkg::MAX_BURST_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  bbf_req_if.sink                   req,
  bbf_rsp_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic [bbf_pkg::CNT_W-1:0] cfg_wr_data
);
  import bbf_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DEPTH_LIM = (DEPTH < 2048) ? DEPTH : 2047;
  localparam logic [CNT_W-1:0] DEPTH_CAP = CNT_W'(DEPTH_LIM);
  localparam logic [LEN_W-1:0] BURST_CAP = LEN_W'(MAX_BURST);

  seq_state_t state;
  seq_state_t state_next;

  logic [AW-1:0]     head;
  logic [CNT_W-1:0]  held;
  logic [TOT_W-1:0]  wr_total;
  logic [TOT_W-1:0]  rd_total;
  logic              ended;
  logic [CNT_W-1:0]  capacity;
  logic [AW-1:0]     rd_ptr;
  logic [LEN_W-1:0]  remain;
  logic              wr_ok;

  logic              out_full;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_valid_r;
  logic              out_last;
  logic              out_wa;
  logic [CNT_W-1:0]  out_count;
  logic [CNT_W-1:0]  out_space;
  logic              out_closed;
  logic              out_eof;
  logic [TOT_W-1:0]  out_wr_total;
  logic [TOT_W-1:0]  out_rd_total;

  logic              accept;
  logic              out_free;
  logic              req_ready;
  logic              load_report;
  logic              load_byte;
  logic              mem_re;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_rdata;
  logic [CNT_W-1:0]  eff_cap;
  logic [CNT_W-1:0]  space;
  logic [CNT_W-1:0]  len_held;
  logic [LEN_W-1:0]  burst_n;
  logic              write_ok;
  logic [AW-1:0]     add_base;
  logic [CNT_W-1:0]  add_off;
  logic [AW-1:0]     add_sum;

  always_comb begin
    eff_cap = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;
    space   = (eff_cap > held) ? (eff_cap - held) : '0;
    if (CNT_W'(req.read_len) < held) begin
      len_held = CNT_W'(req.read_len);
    end else begin
      len_held = held;
    end
    if (len_held > CNT_W'(BURST_CAP)) begin
      burst_n = BURST_CAP;
    end else begin
      burst_n = len_held[LEN_W-1:0];
    end
    write_ok = !ended && (held < eff_cap);
    accept   = req.valid && req_ready;
    out_free = !out_full || rsp.ready;
  end

  // The one address adder serves the write slot, the head advance and the
  // read pointer step.
  always_comb begin
    if (state == ST_LOAD) begin
      add_base = rd_ptr;
      add_off  = CNT_W'(1);
    end else begin
      add_base = head;
      case (req.op)
        OP_WRITE: add_off = held;
        OP_READ:  add_off = CNT_W'(burst_n);
        default:  add_off = len_held;
      endcase
    end
  end

  bbf_wrap_add #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_wrap_add (
    .base   (add_base),
    .offset (add_off),
    .sum    (add_sum)
  );

  assign mem_we = accept && (req.op == OP_WRITE) && write_ok;

  bbf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (add_sum),
    .wdata (req.data_byte),
    .re    (mem_re),
    .raddr (rd_ptr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((req.op == OP_READ || req.op == OP_PEEK) && burst_n != '0) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_next = (remain == LEN_W'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    load_report = 1'b0;
    load_byte   = 1'b0;
    mem_re      = 1'b0;
    case (state)
      ST_IDLE:   req_ready   = 1'b1;
      ST_REPORT: load_report = out_free;
      ST_FETCH:  mem_re      = 1'b1;
      ST_LOAD:   load_byte   = out_free;
      default:   req_ready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      held     <= '0;
      wr_total <= '0;
      rd_total <= '0;
      ended    <= 1'b0;
      capacity <= CAP_RESET;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (load_report || load_byte) begin
        out_full <= 1'b1;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
      if (accept) begin
        wr_ok <= (req.op == OP_WRITE) && write_ok;
        case (req.op)
          OP_WRITE: begin
            if (write_ok) begin
              held     <= held + CNT_W'(1);
              wr_total <= wr_total + TOT_W'(1);
            end
          end
          OP_READ: begin
            head     <= add_sum;
            held     <= held - CNT_W'(burst_n);
            rd_total <= rd_total + TOT_W'(burst_n);
            rd_ptr   <= head;
            remain   <= burst_n;
          end
          OP_PEEK: begin
            rd_ptr <= head;
            remain <= burst_n;
          end
          OP_POP: begin
            head     <= add_sum;
            held     <= held - len_held;
            rd_total <= rd_total + TOT_W'(len_held);
          end
          OP_END: begin
            ended <= 1'b1;
          end
          default: begin
            ended <= ended;
          end
        endcase
      end
      if (load_byte) begin
        rd_ptr <= add_sum;
        remain <= remain - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_report || load_byte) begin
      out_byte_r   <= load_byte ? mem_rdata : '0;
      out_valid_r  <= load_byte;
      out_last     <= load_report || (remain == LEN_W'(1));
      out_wa       <= load_report && wr_ok;
      out_count    <= held;
      out_space    <= space;
      out_closed   <= ended;
      out_eof      <= ended && (held == '0);
      out_wr_total <= wr_total;
      out_rd_total <= rd_total;
    end
  end

  assign req.ready          = req_ready;
  assign rsp.valid          = out_full;
  assign rsp.out_byte       = out_byte_r;
  assign rsp.out_valid      = out_valid_r;
  assign rsp.last           = out_last;
  assign rsp.write_accepted = out_wa;
  assign rsp.buffered_count = out_count;
  assign rsp.space_left     = out_space;
  assign rsp.input_closed   = out_closed;
  assign rsp.at_eof         = out_eof;
  assign rsp.total_written  = out_wr_total;
  assign rsp.total_read     = out_rd_total;

`ifndef SYNTHESIS
  // The FIFO never holds more bytes than the store has entries.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= DEPTH_CAP)
    else $error("held count exceeds the store depth");

  // A burst in progress always has bytes left to fetch.
  a_burst_remain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH || state == ST_LOAD) |-> remain != '0)
    else $error("burst sequencing with nothing remaining");

  // While a non-final byte waits at the output, the burst is still running.
  a_nonlast_busy: assert property (@(posedge clk) disable iff (rst)
    (out_full && !out_last) |-> (state == ST_FETCH || state == ST_LOAD))
    else $error("non-final result pending with the sequencer idle");

  // A stored byte raises the held count by exactly one.
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> held == $past(held) + CNT_W'(1))
    else $error("held count did not follow a stored byte");
`endif

endmodule

// ----- rtl/core/bbf_store.sv -----
// Byte storage of the FIFO: one write port and one registered read port.
// Depends on bbf_pkg for the byte width.
module bbf_store #(
  parameter int DEPTH = bbf_pkg::DEPTH_DEF,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bbf_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bbf_pkg::BYTE_W-1:0] rdata
);
  import bbf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/bbf_wrap_add.sv -----
// Shared address unit: adds an offset to a ring index and wraps it at DEPTH.
// Depends on bbf_pkg for the count width; the offset never exceeds DEPTH.
module bbf_wrap_add #(
  parameter int DEPTH = bbf_pkg::DEPTH_DEF,
  parameter int AW    = 10
) (
  input  logic [AW-1:0]             base,
  input  logic [bbf_pkg::CNT_W-1:0] offset,
  output logic [AW-1:0]             sum
);
  import bbf_pkg::*;

  localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

  logic [SW-1:0] raw;
  logic [SW-1:0] wrapped;

  always_comb begin
    raw = SW'(base) + SW'(offset);
    if (raw >= DEPTH_S) begin
      wrapped = raw - DEPTH_S;
    end else begin
      wrapped = raw;
    end
    sum = wrapped[AW-1:0];
  end

endmodule

// ----- bench/bounded_byte_fifo_with_eof_test.sv -----
`timescale 1ns / 1ps
// Testbench of bounded_byte_fifo_with_eof: directed and random operation streams,
// each result checked field by field against an in-bench byte FIFO predictor.
// Depends on bbf_pkg, bbf_req_if, bbf_rsp_if and the block's RTL.
module bounded_byte_fifo_with_eof_test;
  import bbf_pkg::*;

  localparam int FIFO_DEPTH    = DEPTH_DEF;
  localparam int BURST_MAX     = MAX_BURST_DEF;
  localparam int HEAD_W        = $clog2(FIFO_DEPTH);
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int REPORT_LIMIT  = 10;
  localparam int RANDOM_ITEMS  = 250;
  localparam int PHASES        = 6;
  localparam int RUN_LIMIT_NS  = 200_000_000;

  localparam logic [OP_W-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [CNT_W-1:0] FILL_CAP       = 11'd70;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              last;
    logic              write_accepted;
    logic [CNT_W-1:0]  buffered_count;
    logic [CNT_W-1:0]  space_left;
    logic              input_closed;
    logic              at_eof;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
  } fifo_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  bbf_req_if req_ch();
  bbf_rsp_if rsp_ch();

  bounded_byte_fifo_with_eof dut (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [BYTE_W-1:0] fifo_bytes [FIFO_DEPTH];
  logic [HEAD_W-1:0] fifo_head;
  logic [CNT_W-1:0]  fifo_held;
  logic [TOT_W-1:0]  bytes_accepted;
  logic [TOT_W-1:0]  bytes_popped;
  logic              stream_closed;
  logic [CNT_W-1:0]  capacity_setting;

  fifo_result_t due_results[$];
  int           mismatch_count = 0;
  int           results_seen   = 0;
  bit           no_idle        = 1'b0;
  int           hold_request   = 0;
  int           hold_serial    = 0;

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 70) return LEN_W'($urandom_range(8, 1));
    if (r < 90) return LEN_W'($urandom_range(64, 9));
    return LEN_W'($urandom_range(127, 65));
  endfunction

  function automatic logic [OP_W-1:0] pick_consumer();
    case ($urandom_range(2))
      0: return OP_READ;
      1: return OP_PEEK;
      default: return OP_POP;
    endcase
  endfunction

  function automatic fifo_result_t status_now(input logic [BYTE_W-1:0] b,
                                              input logic delivered,
                                              input logic is_last,
                                              input logic stored);
    fifo_result_t r;
    logic [CNT_W-1:0] cap;
    cap = (capacity_setting > CNT_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : capacity_setting;
    r.out_byte       = b;
    r.out_valid      = delivered;
    r.last           = is_last;
    r.write_accepted = stored;
    r.buffered_count = fifo_held;
    r.space_left     = (cap > fifo_held) ? cap - fifo_held : '0;
    r.input_closed   = stream_closed;
    r.at_eof         = stream_closed && (fifo_held == '0);
    r.total_written  = bytes_accepted;
    r.total_read     = bytes_popped;
    return r;
  endfunction

  function automatic void queue_result(input fifo_result_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void drop_bytes(input int n);
    fifo_head    = fifo_head + HEAD_W'(n);
    fifo_held    = fifo_held - CNT_W'(n);
    bytes_popped = bytes_popped + TOT_W'(n);
  endfunction

  function automatic void apply_fifo_op(input logic [OP_W-1:0] op,
                                        input logic [BYTE_W-1:0] data,
                                        input logic [LEN_W-1:0] len);
    logic [BYTE_W-1:0] grabbed [BURST_MAX];
    logic [CNT_W-1:0]  cap;
    logic              stored;
    int                n;
    cap = (capacity_setting > CNT_W'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH) : capacity_setting;
    n = int'(len);
    if (n > int'(fifo_held)) n = int'(fifo_held);
    if (op == OP_READ || op == OP_PEEK) begin
      if (n > BURST_MAX) n = BURST_MAX;
      for (int i = 0; i < n; i++) grabbed[i] = fifo_bytes[fifo_head + HEAD_W'(i)];
      if (op == OP_READ) drop_bytes(n);
      if (n == 0) queue_result(status_now('0, 1'b0, 1'b1, 1'b0));
      for (int i = 0; i < n; i++)
        queue_result(status_now(grabbed[i], 1'b1, i == n - 1, 1'b0));
    end else begin
      stored = 1'b0;
      case (op)
        OP_WRITE: begin
          if (!stream_closed && fifo_held < cap) begin
            fifo_bytes[fifo_head + fifo_held[HEAD_W-1:0]] = data;
            fifo_held      = fifo_held + CNT_W'(1);
            bytes_accepted = bytes_accepted + TOT_W'(1);
            stored         = 1'b1;
          end
        end
        OP_POP: drop_bytes(n);
        OP_END: stream_closed = 1'b1;
        default: ;
      endcase
      queue_result(status_now('0, 1'b0, 1'b1, stored));
    end
  endfunction

  task automatic note_mismatch(input string what, input logic [TOT_W-1:0] want,
                               input logic [TOT_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("Mismatch at result %0d, %s: expected %0h, got %0h",
               results_seen, what, want, got);
  endtask

  // A request transaction is taken at the first rising edge with ready high.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                         input logic [LEN_W-1:0] len);
    repeat (idle_len()) @(negedge clk);
    @(negedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.data_byte <= data;
    req_ch.read_len  <= len;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_fifo_op(op, data, len);
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] cap);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    capacity_setting = cap;
  endtask

  task automatic test_empty_and_unused();
    send_op(OP_READ, 8'h00, 7'd0);
    send_op(OP_READ, 8'hFF, 7'd64);
    send_op(OP_PEEK, 8'h00, 7'd127);
    send_op(OP_POP, 8'hFF, 7'd127);
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++) send_op(OP_W'(c), 8'hFF, 7'd127);
  endtask

  task automatic test_byte_extremes();
    send_op(OP_WRITE, 8'h00, 7'd127);
    send_op(OP_WRITE, 8'hFF, 7'd0);
    send_op(OP_WRITE, 8'hA5, 7'd0);
    send_op(OP_WRITE, 8'h5A, 7'd0);
    send_op(OP_PEEK, 8'h00, 7'd1);
    send_op(OP_PEEK, 8'h00, 7'd127);
    send_op(OP_READ, 8'h00, 7'd2);
    send_op(OP_POP, 8'h00, 7'd1);
    send_op(OP_READ, 8'h00, 7'd64);
  endtask

  task automatic test_capacity_limits();
    set_capacity(11'd0);
    send_op(OP_WRITE, 8'h11, 7'd0);
    set_capacity(11'd1);
    send_op(OP_WRITE, 8'h22, 7'd0);
    send_op(OP_WRITE, 8'h33, 7'd0);
    send_op(OP_READ, 8'h00, 7'd1);
    set_capacity(11'd2047);
    repeat (6) send_op(OP_WRITE, rand_byte(), 7'd0);
    set_capacity(11'd2);
    send_op(OP_WRITE, 8'h44, 7'd0);
    send_op(OP_POP, 8'h00, 7'd5);
    send_op(OP_WRITE, 8'h55, 7'd0);
    send_op(OP_WRITE, 8'h66, 7'd0);
    send_op(OP_READ, 8'h00, 7'd64);
  endtask

  task automatic test_output_backpressure();
    set_capacity(CAP_RESET);
    hold_request = 200;
    hold_serial++;
    repeat (12) send_op(OP_WRITE, rand_byte(), rand_len());
    send_op(OP_READ, rand_byte(), 7'd12);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic test_random_traffic(input int items);
    logic [CNT_W-1:0] caps [PHASES];
    int sent;
    int burst;
    int pick;
    caps = '{CAP_RESET, 11'd9, 11'd2047, 11'd1, 11'd40, 11'd1023};
    sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(caps[p]);
      no_idle = (p == 3);
      while (sent < (items / PHASES) * (p + 1)) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          burst = $urandom_range(24, 1);
          repeat (burst) send_op(OP_WRITE, rand_byte(), rand_len());
          send_op(pick_consumer(), rand_byte(), rand_len());
          sent += burst + 1;
        end else if (pick < 85) begin
          send_op(pick_consumer(), rand_byte(), rand_len());
          sent++;
        end else if (pick < 92) begin
          send_op(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), rand_byte(),
                  LEN_W'($urandom_range(127)));
        end else begin
          send_op(OP_WRITE, rand_byte(), LEN_W'($urandom_range(127)));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_fill_and_drain();
    set_capacity(FILL_CAP);
    no_idle = 1'b1;
    while (fifo_held < FILL_CAP) send_op(OP_WRITE, rand_byte(), rand_len());
    no_idle = 1'b0;
    send_op(OP_WRITE, rand_byte(), 7'd0);
    send_op(OP_PEEK, rand_byte(), 7'd127);
    while (fifo_held != '0)
      send_op(($urandom_range(3) == 0) ? OP_POP : OP_READ, rand_byte(),
              LEN_W'($urandom_range(127, 20)));
  endtask

  task automatic test_end_of_input();
    repeat (3) send_op(OP_WRITE, rand_byte(), 7'd0);
    send_op(OP_END, 8'hFF, 7'd127);
    send_op(OP_WRITE, rand_byte(), 7'd0);
    send_op(OP_PEEK, 8'h00, 7'd2);
    send_op(OP_READ, 8'h00, 7'd127);
    send_op(OP_READ, 8'h00, 7'd5);
    send_op(OP_POP, 8'h00, 7'd1);
    send_op(OP_END, 8'h00, 7'd0);
    send_op(OP_SPARE_LAST, 8'hFF, 7'd127);
  endtask

  always @(posedge clk) begin : check_results
    fifo_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("unexpected result", '0, TOT_W'(rsp_ch.out_byte));
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (rsp_ch.out_byte !== want.out_byte)
          note_mismatch("out_byte", TOT_W'(want.out_byte), TOT_W'(rsp_ch.out_byte));
        if (rsp_ch.out_valid !== want.out_valid)
          note_mismatch("out_valid", TOT_W'(want.out_valid), TOT_W'(rsp_ch.out_valid));
        if (rsp_ch.last !== want.last)
          note_mismatch("last", TOT_W'(want.last), TOT_W'(rsp_ch.last));
        if (rsp_ch.write_accepted !== want.write_accepted)
          note_mismatch("write_accepted", TOT_W'(want.write_accepted),
                        TOT_W'(rsp_ch.write_accepted));
        if (rsp_ch.buffered_count !== want.buffered_count)
          note_mismatch("buffered_count", TOT_W'(want.buffered_count),
                        TOT_W'(rsp_ch.buffered_count));
        if (rsp_ch.space_left !== want.space_left)
          note_mismatch("space_left", TOT_W'(want.space_left), TOT_W'(rsp_ch.space_left));
        if (rsp_ch.input_closed !== want.input_closed)
          note_mismatch("input_closed", TOT_W'(want.input_closed),
                        TOT_W'(rsp_ch.input_closed));
        if (rsp_ch.at_eof !== want.at_eof)
          note_mismatch("at_eof", TOT_W'(want.at_eof), TOT_W'(rsp_ch.at_eof));
        if (rsp_ch.total_written !== want.total_written)
          note_mismatch("total_written", want.total_written, rsp_ch.total_written);
        if (rsp_ch.total_read !== want.total_read)
          note_mismatch("total_read", want.total_read, rsp_ch.total_read);
      end
      results_seen++;
    end
  end

  initial begin : drive_rsp_ready
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_seen != hold_serial) begin
        hold_seen = hold_serial;
        hold_left = hold_request;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  initial begin : run_tests
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = OP_WRITE;
    req_ch.data_byte = '0;
    req_ch.read_len  = '0;
    fifo_head        = '0;
    fifo_held        = '0;
    bytes_accepted   = '0;
    bytes_popped     = '0;
    stream_closed    = 1'b0;
    capacity_setting = CAP_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_empty_and_unused();
    test_byte_extremes();
    test_capacity_limits();
    test_output_backpressure();
    test_random_traffic(RANDOM_ITEMS);
    test_fill_and_drain();
    test_end_of_input();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
